[rtl/escaped_frame_crc_receiver_top_defines.svh]
// ----------------------------------------------------------------------------
// escaped frame receiver assertion macros
// shared assertion forms, clocked on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef ESCAPED_FRAME_CRC_RECEIVER_TOP_DEFINES_SVH
`define ESCAPED_FRAME_CRC_RECEIVER_TOP_DEFINES_SVH

// same-cycle implication
`define EFCR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("efcr assertion failed");

// next-cycle implication
`define EFCR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("efcr assertion failed");

`endif

[rtl/efcr_pkg.sv]
// ----------------------------------------------------------------------------
// efcr_pkg
// types, constants and the crc16 byte update for the escaped frame receiver
// ----------------------------------------------------------------------------
`default_nettype none

package efcr_pkg;

  localparam logic [7:0]  START_MARK = 8'h7E;
  localparam logic [7:0]  END_MARK   = 8'h7F;
  localparam logic [7:0]  ESC_MARK   = 8'h7D;
  localparam logic [7:0]  ESC_FLIP   = 8'h20;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [15:0] TICK_MAX   = 16'hFFFF;

  localparam logic [15:0] MAX_LEN_RESET = 16'd4096;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  localparam int ADDR_W      = 3;
  localparam int REG_IDX_LSB = 2;

  typedef enum logic [0:0] {
    REG_MAX_LEN = 1'b0,
    REG_TIMEOUT = 1'b1
  } efcr_reg_t;

  typedef enum logic [0:0] {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } efcr_op_t;

  typedef enum logic [0:0] {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } efcr_kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_CRC_ERR   = 3'd1,
    ST_TOO_BIG   = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_PREMATURE = 3'd4,
    ST_TIMEOUT   = 3'd5
  } efcr_status_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_HEADER  = 3'b010,
    PH_PAYLOAD = 3'b100
  } efcr_phase_t;

  // header byte positions
  localparam logic [2:0] HDR_LEN_B1 = 3'd1;
  localparam logic [2:0] HDR_LEN_B3 = 3'd3;
  localparam logic [2:0] HDR_CRC_B0 = 3'd4;
  localparam logic [2:0] HDR_CRC_B1 = 3'd5;
  localparam logic [2:0] HDR_TYPE   = 3'd6;

  typedef struct packed {
    logic [15:0] max_len;
    logic [15:0] timeout;
  } efcr_cfg_t;

  // reflected crc16 (0xA001), one byte, bit loop unrolled
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/efcr_cfg_regs.sv]
// ----------------------------------------------------------------------------
// efcr_cfg_regs
// apb register file holding the length limit and the tick timeout
// ----------------------------------------------------------------------------
`default_nettype none

module efcr_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [efcr_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output efcr_pkg::efcr_cfg_t              cfg
);

  efcr_pkg::efcr_reg_t reg_sel;
  logic                wr_en;

  assign pready  = 1'b1;
  assign reg_sel = efcr_pkg::efcr_reg_t'(paddr[efcr_pkg::REG_IDX_LSB]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_len <= efcr_pkg::MAX_LEN_RESET;
      cfg.timeout <= efcr_pkg::TIMEOUT_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        efcr_pkg::REG_MAX_LEN: cfg.max_len <= pwdata[15:0];
        efcr_pkg::REG_TIMEOUT: cfg.timeout <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      efcr_pkg::REG_MAX_LEN: prdata = {16'h0000, cfg.max_len};
      efcr_pkg::REG_TIMEOUT: prdata = {16'h0000, cfg.timeout};
      default:               prdata = 32'h0000_0000;
    endcase
  end

endmodule

`default_nettype wire

[rtl/escaped_frame_crc_receiver_top.sv]
// ----------------------------------------------------------------------------
// escaped_frame_crc_receiver_top: byte-stuffed frame receiver with crc16 check
// flow: input register, then result register; a stalled output holds the item
// throughput: 1 item per cycle when out_stall is low; combinational crc update
// reset: synchronous rst returns to start hunt, limits to 4096 and 1000 ticks
// ----------------------------------------------------------------------------
`default_nettype none
`include "escaped_frame_crc_receiver_top_defines.svh"

module escaped_frame_crc_receiver_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // input channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        op,
  input  wire logic [7:0]                  rx_byte,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             kind,
  output logic [7:0]                       payload_byte,
  output logic [2:0]                       status,
  output logic                             last,
  // configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [efcr_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  efcr_pkg::efcr_cfg_t cfg;

  efcr_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // --------------------------------------------------------------------------
  // input register
  // --------------------------------------------------------------------------
  logic               s1_valid;
  efcr_pkg::efcr_op_t s1_op;
  logic [7:0]         s1_byte;
  logic               s1_advance;
  logic               in_take;

  // the held item moves on whenever the result register is free or draining
  assign s1_advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall   = s1_valid && !s1_advance;
  assign in_take    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  // payload of the input register, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op   <= efcr_pkg::efcr_op_t'(op);
      s1_byte <= rx_byte;
    end
  end

  // --------------------------------------------------------------------------
  // frame state
  // --------------------------------------------------------------------------
  efcr_pkg::efcr_phase_t phase, phase_next;
  logic                  esc_pending, esc_pending_next;
  logic [2:0]            header_count, header_count_next;
  logic [15:0]           len_lo, len_lo_next;       // low half of the header length
  logic                  len_hi_nz, len_hi_nz_next; // upper half is nonzero
  logic [15:0]           header_crc, header_crc_next;
  logic [15:0]           running_crc, running_crc_next;
  logic [15:0]           payload_count, payload_count_next;
  logic [15:0]           elapsed, elapsed_next;

  // result of the item in the input register
  logic                   res_valid;
  efcr_pkg::efcr_kind_t   res_kind;
  logic [7:0]             res_byte;
  efcr_pkg::efcr_status_t res_status;
  logic                   frame_clear;
  logic                   frame_start;
  logic [7:0]             data_b;
  logic [15:0]            crc_upd;

  // unescaped value of the byte when an escape is pending
  assign data_b  = esc_pending ? (s1_byte ^ efcr_pkg::ESC_FLIP) : s1_byte;
  assign crc_upd = efcr_pkg::crc16_byte(running_crc, data_b);

  always_comb begin
    phase_next         = phase;
    esc_pending_next   = esc_pending;
    header_count_next  = header_count;
    len_lo_next        = len_lo;
    len_hi_nz_next     = len_hi_nz;
    header_crc_next    = header_crc;
    running_crc_next   = running_crc;
    payload_count_next = payload_count;
    elapsed_next       = elapsed;
    res_valid          = 1'b0;
    res_kind           = efcr_pkg::KIND_DATA;
    res_byte           = 8'h00;
    res_status         = efcr_pkg::ST_OK;
    frame_clear        = 1'b0;
    frame_start        = 1'b0;

    if (s1_advance) begin
      if (s1_op == efcr_pkg::OP_TICK) begin
        // ticks only count inside a frame
        if (phase != efcr_pkg::PH_IDLE) begin
          if (elapsed >= cfg.timeout) begin
            res_valid   = 1'b1;
            res_kind    = efcr_pkg::KIND_STATUS;
            res_status  = efcr_pkg::ST_TIMEOUT;
            frame_clear = 1'b1;
          end else if (elapsed != efcr_pkg::TICK_MAX) begin
            elapsed_next = elapsed + 16'd1;
          end
        end
      end else begin
        unique case (phase)
          efcr_pkg::PH_IDLE: begin
            // hunt for the start marker, drop everything else
            if (s1_byte == efcr_pkg::START_MARK) begin
              frame_clear = 1'b1;
              frame_start = 1'b1;
            end
          end
          efcr_pkg::PH_HEADER: begin
            // raw little-endian header: length, crc, type
            priority if (header_count == 3'd0) begin
              len_lo_next[7:0] = s1_byte;
            end else if (header_count == efcr_pkg::HDR_LEN_B1) begin
              len_lo_next[15:8] = s1_byte;
            end else if (header_count <= efcr_pkg::HDR_LEN_B3) begin
              len_hi_nz_next = len_hi_nz || (s1_byte != 8'h00);
            end else if (header_count == efcr_pkg::HDR_CRC_B0) begin
              header_crc_next[7:0] = s1_byte;
            end else if (header_count == efcr_pkg::HDR_CRC_B1) begin
              header_crc_next[15:8] = s1_byte;
            end else begin
            end

            if (header_count >= efcr_pkg::HDR_TYPE) begin
              header_count_next = 3'd0;
              if (len_hi_nz || (len_lo > cfg.max_len)) begin
                res_valid   = 1'b1;
                res_kind    = efcr_pkg::KIND_STATUS;
                res_status  = efcr_pkg::ST_TOO_BIG;
                frame_clear = 1'b1;
              end else begin
                phase_next         = efcr_pkg::PH_PAYLOAD;
                payload_count_next = 16'd0;
                running_crc_next   = efcr_pkg::CRC_INIT;
              end
            end else begin
              header_count_next = header_count + 3'd1;
            end
          end
          efcr_pkg::PH_PAYLOAD: begin
            if (!esc_pending && (s1_byte == efcr_pkg::ESC_MARK)) begin
              esc_pending_next = 1'b1;
            end else begin
              esc_pending_next = 1'b0;
              if (!esc_pending && (s1_byte == efcr_pkg::END_MARK)) begin
                // end marker: length and crc decide the status
                res_valid   = 1'b1;
                res_kind    = efcr_pkg::KIND_STATUS;
                frame_clear = 1'b1;
                if (payload_count != len_lo) begin
                  res_status = efcr_pkg::ST_PREMATURE;
                end else if (running_crc != header_crc) begin
                  res_status = efcr_pkg::ST_CRC_ERR;
                end else begin
                  res_status = efcr_pkg::ST_OK;
                end
              end else if (payload_count >= len_lo) begin
                res_valid   = 1'b1;
                res_kind    = efcr_pkg::KIND_STATUS;
                res_status  = efcr_pkg::ST_OVERFLOW;
                frame_clear = 1'b1;
              end else begin
                // data byte goes out and into the crc
                res_valid          = 1'b1;
                res_byte           = data_b;
                payload_count_next = payload_count + 16'd1;
                running_crc_next   = crc_upd;
              end
            end
          end
          default: begin
            frame_clear = 1'b1;
          end
        endcase
      end
    end

    // any abort, frame end or new start wipes the frame state
    if (frame_clear) begin
      phase_next         = efcr_pkg::PH_IDLE;
      esc_pending_next   = 1'b0;
      header_count_next  = 3'd0;
      len_lo_next        = 16'd0;
      len_hi_nz_next     = 1'b0;
      header_crc_next    = 16'd0;
      running_crc_next   = efcr_pkg::CRC_INIT;
      payload_count_next = 16'd0;
      elapsed_next       = 16'd0;
    end
    if (frame_start) begin
      phase_next = efcr_pkg::PH_HEADER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= efcr_pkg::PH_IDLE;
      esc_pending   <= 1'b0;
      header_count  <= 3'd0;
      len_lo        <= 16'd0;
      len_hi_nz     <= 1'b0;
      header_crc    <= 16'd0;
      running_crc   <= efcr_pkg::CRC_INIT;
      payload_count <= 16'd0;
      elapsed       <= 16'd0;
    end else begin
      phase         <= phase_next;
      esc_pending   <= esc_pending_next;
      header_count  <= header_count_next;
      len_lo        <= len_lo_next;
      len_hi_nz     <= len_hi_nz_next;
      header_crc    <= header_crc_next;
      running_crc   <= running_crc_next;
      payload_count <= payload_count_next;
      elapsed       <= elapsed_next;
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && res_valid) begin
      kind         <= res_kind;
      payload_byte <= res_byte;
      status       <= res_status;
      last         <= (res_kind == efcr_pkg::KIND_STATUS);
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `EFCR_ASSERT_SAME(a_data_item_clean,
    out_valid && (kind == efcr_pkg::KIND_DATA), !last && (status == efcr_pkg::ST_OK))
  `EFCR_ASSERT_SAME(a_escape_only_in_payload,
    esc_pending, phase == efcr_pkg::PH_PAYLOAD)
  `EFCR_ASSERT_SAME(a_payload_within_length,
    phase == efcr_pkg::PH_PAYLOAD, !len_hi_nz && (payload_count <= len_lo))
  `EFCR_ASSERT_NEXT(a_status_returns_idle,
    s1_advance && res_valid && (res_kind == efcr_pkg::KIND_STATUS),
    (phase == efcr_pkg::PH_IDLE) && (elapsed == 16'd0))

endmodule

`default_nettype wire

[tb/escaped_frame_crc_receiver_top_tb.sv]
// ----------------------------------------------------------------------------
// escaped_frame_crc_receiver_top_tb: self-checking bench for the frame receiver
// a directed table walks idle hunting, oversize headers, escapes and early
// ends, checked mostly against results typed into it; random phases then feed
// mostly well-formed frames with random content plus noise, under several limit
// settings and idle patterns, checked against a cycle-free model of the receiver
// ----------------------------------------------------------------------------
module escaped_frame_crc_receiver_top_tb;
  import efcr_pkg::*;

  // cycles with no handshake of any kind before the run is declared hung
  localparam int QUIET_LIMIT = 4000;
  // minimum items per random phase, six phases
  localparam int PHASE_ITEMS = 125;
  localparam int NUM_PHASES  = 6;

  // how a table row is checked: by the model, by a result typed in, or not at all
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_DATA,
    CHK_STATUS
  } chk_t;

  typedef struct packed {
    efcr_op_t     op;
    logic [7:0]   rx;
    chk_t         chk;
    logic [7:0]   want_byte;
    efcr_status_t want_st;
  } line_item_t;

  typedef struct packed {
    efcr_kind_t   kind;
    logic [7:0]   data;
    efcr_status_t st;
    logic         last;
  } frame_res_t;

  // ---------------------------------------------------------------- signals
  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  efcr_op_t            op = OP_BYTE;
  logic [7:0]          rx_byte = 8'h00;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                kind;
  logic [7:0]          payload_byte;
  logic [2:0]          status;
  logic                last;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [31:0]         pwdata = 32'h0;
  logic [31:0]         prdata;
  logic                pready;

  // check mode of the item currently on the input port
  chk_t                cur_chk = CHK_MODEL;
  logic [7:0]          cur_want_byte = 8'h00;
  efcr_status_t        cur_want_st = ST_OK;

  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;
  int                  err_count = 0;
  int                  quiet_cycles = 0;

  frame_res_t          pending_results[$];
  line_item_t          line_q[$];

  // ------------------------------------------------------- receiver tracker
  // limits as last written over the register port
  logic [15:0]         cfg_max_len;
  logic [15:0]         cfg_timeout;
  // frame state mirrored from the line
  efcr_phase_t         trk_phase;
  logic                trk_esc;
  logic [2:0]          trk_hdr_idx;
  logic [31:0]         trk_len;
  logic [15:0]         trk_hdr_crc;
  logic [15:0]         trk_crc;
  logic [15:0]         trk_count;
  logic [15:0]         trk_ticks;

  // the stimulus table: idle noise, an oversize header, an escaped frame
  // checked against its header crc, and a frame cut short
  line_item_t directed_rows [32] = '{
    '{OP_TICK, 8'h00, CHK_NONE,   8'h00, ST_OK},        // tick while hunting
    '{OP_BYTE, 8'hFF, CHK_NONE,   8'h00, ST_OK},        // idle byte dropped
    '{OP_BYTE, 8'h7E, CHK_NONE,   8'h00, ST_OK},        // start
    '{OP_BYTE, 8'hFF, CHK_NONE,   8'h00, ST_OK},        // length 0xffffffff
    '{OP_BYTE, 8'hFF, CHK_NONE,   8'h00, ST_OK},
    '{OP_BYTE, 8'hFF, CHK_NONE,   8'h00, ST_OK},
    '{OP_BYTE, 8'hFF, CHK_NONE,   8'h00, ST_OK},
    '{OP_BYTE, 8'h7D, CHK_NONE,   8'h00, ST_OK},        // markers raw in header
    '{OP_BYTE, 8'h7E, CHK_NONE,   8'h00, ST_OK},
    '{OP_BYTE, 8'hFF, CHK_STATUS, 8'h00, ST_TOO_BIG},   // type byte closes header
    '{OP_BYTE, 8'h7E, CHK_NONE,   8'h00, ST_OK},        // start
    '{OP_BYTE, 8'h02, CHK_NONE,   8'h00, ST_OK},        // length 2
    '{OP_BYTE, 8'h00, CHK_NONE,   8'h00, ST_OK},
    '{OP_BYTE, 8'h00, CHK_NONE,   8'h00, ST_OK},
    '{OP_BYTE, 8'h00, CHK_NONE,   8'h00, ST_OK},
    '{OP_BYTE, 8'h00, CHK_NONE,   8'h00, ST_OK},        // header crc 0
    '{OP_BYTE, 8'h00, CHK_NONE,   8'h00, ST_OK},
    '{OP_BYTE, 8'h00, CHK_NONE,   8'h00, ST_OK},        // type
    '{OP_TICK, 8'hFF, CHK_NONE,   8'h00, ST_OK},        // tick inside frame
    '{OP_BYTE, 8'h7D, CHK_NONE,   8'h00, ST_OK},        // escape
    '{OP_BYTE, 8'h5F, CHK_DATA,   8'h7F, ST_OK},        // escaped end mark is data
    '{OP_BYTE, 8'h7E, CHK_DATA,   8'h7E, ST_OK},        // bare start mark is data
    '{OP_BYTE, 8'h7F, CHK_MODEL,  8'h00, ST_OK},        // end, crc compare
    '{OP_BYTE, 8'h7E, CHK_NONE,   8'h00, ST_OK},        // start
    '{OP_BYTE, 8'h01, CHK_NONE,   8'h00, ST_OK},        // length 1
    '{OP_BYTE, 8'h00, CHK_NONE,   8'h00, ST_OK},
    '{OP_BYTE, 8'h00, CHK_NONE,   8'h00, ST_OK},
    '{OP_BYTE, 8'h00, CHK_NONE,   8'h00, ST_OK},
    '{OP_BYTE, 8'h00, CHK_NONE,   8'h00, ST_OK},
    '{OP_BYTE, 8'h00, CHK_NONE,   8'h00, ST_OK},
    '{OP_BYTE, 8'h00, CHK_NONE,   8'h00, ST_OK},
    '{OP_BYTE, 8'h7F, CHK_STATUS, 8'h00, ST_PREMATURE}  // end before any data
  };

  // ---------------------------------------------------------------- the block
  escaped_frame_crc_receiver_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .payload_byte (payload_byte),
    .status       (status),
    .last         (last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  // ------------------------------------------------------------- prediction
  // reflected crc16, shifted one bit at a time
  function automatic logic [15:0] crc16_update(logic [15:0] c, logic [7:0] d);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ d[i];
      c = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  task automatic clear_tracker();
    trk_phase   = PH_IDLE;
    trk_esc     = 1'b0;
    trk_hdr_idx = '0;
    trk_len     = '0;
    trk_hdr_crc = '0;
    trk_crc     = CRC_INIT;
    trk_count   = '0;
    trk_ticks   = '0;
  endtask

  // advance the tracker by one item; got is set when a result is due
  task automatic track_item(input efcr_op_t o, input logic [7:0] b,
                            output bit got, output frame_res_t r);
    logic [7:0]   d;
    logic         was_esc;
    bit           closes;
    efcr_status_t fin;
    got     = 1'b0;
    closes  = 1'b0;
    fin     = ST_OK;
    d       = b;
    was_esc = 1'b0;
    r       = '{KIND_DATA, 8'h00, ST_OK, 1'b0};
    if (o == OP_TICK) begin
      // ticks only matter inside a frame
      if (trk_phase != PH_IDLE) begin
        if (trk_ticks >= cfg_timeout) begin
          closes = 1'b1;
          fin    = ST_TIMEOUT;
        end else if (trk_ticks != TICK_MAX) begin
          trk_ticks++;
        end
      end
    end else if (trk_phase == PH_IDLE) begin
      if (b == START_MARK) begin
        clear_tracker();
        trk_phase = PH_HEADER;
      end
    end else if (trk_phase == PH_HEADER) begin
      // little-endian length, then crc, then an ignored type byte
      if (trk_hdr_idx <= HDR_LEN_B3) begin
        trk_len[8*trk_hdr_idx +: 8] = b;
      end else if (trk_hdr_idx <= HDR_CRC_B1) begin
        trk_hdr_crc[8*(trk_hdr_idx - HDR_CRC_B0) +: 8] = b;
      end
      if (trk_hdr_idx == HDR_TYPE) begin
        trk_hdr_idx = '0;
        if (trk_len > {16'h0000, cfg_max_len}) begin
          closes = 1'b1;
          fin    = ST_TOO_BIG;
        end else begin
          trk_phase = PH_PAYLOAD;
          trk_count = '0;
          trk_crc   = CRC_INIT;
        end
      end else begin
        trk_hdr_idx++;
      end
    end else begin
      if (trk_esc) begin
        d       = b ^ ESC_FLIP;
        trk_esc = 1'b0;
        was_esc = 1'b1;
      end else if (b == ESC_MARK) begin
        trk_esc = 1'b1;
      end
      // a bare escape only arms the flag
      if (!trk_esc) begin
        if (!was_esc && d == END_MARK) begin
          closes = 1'b1;
          if ({16'h0000, trk_count} != trk_len) begin
            fin = ST_PREMATURE;
          end else if (trk_crc == trk_hdr_crc) begin
            fin = ST_OK;
          end else begin
            fin = ST_CRC_ERR;
          end
        end else if ({16'h0000, trk_count} >= trk_len) begin
          closes = 1'b1;
          fin    = ST_OVERFLOW;
        end else begin
          trk_count++;
          trk_crc = crc16_update(trk_crc, d);
          got     = 1'b1;
          r.data  = d;
        end
      end
    end
    if (closes) begin
      got = 1'b1;
      r   = '{KIND_STATUS, 8'h00, fin, 1'b1};
      clear_tracker();
    end
  endtask

  // --------------------------------------------------------------- checking
  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
    err_count++;
  endtask

  // results are checked before the new item is folded in; latency keeps
  // them apart
  always @(posedge clk) begin
    bit         got;
    frame_res_t r;
    frame_res_t w;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending", 32'h0,
                          {19'h0, kind, payload_byte, status, last});
        end else begin
          w = pending_results.pop_front();
          if (kind != w.kind)
            report_mismatch("kind", 32'(w.kind), 32'(kind));
          if (payload_byte != w.data)
            report_mismatch("payload_byte", 32'(w.data), 32'(payload_byte));
          if (status != w.st)
            report_mismatch("status", 32'(w.st), 32'(status));
          if (last != w.last)
            report_mismatch("last", 32'(w.last), 32'(last));
        end
      end
      if (in_valid && !in_stall) begin
        track_item(op, rx_byte, got, r);
        case (cur_chk)
          CHK_MODEL: begin
            if (got) pending_results.push_back(r);
          end
          CHK_DATA: begin
            pending_results.push_back('{KIND_DATA, cur_want_byte, ST_OK, 1'b0});
          end
          CHK_STATUS: begin
            pending_results.push_back('{KIND_STATUS, 8'h00, cur_want_st, 1'b1});
          end
          default: ;
        endcase
      end
    end
  end

  // watchdog: any handshake on either channel or the register port counts
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("escaped_frame_crc_receiver_top verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // receiver side back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // ------------------------------------------------------------ register port
  // all port tasks start and end on a falling edge
  task automatic reg_write(input efcr_reg_t r, input logic [15:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(r) << REG_IDX_LSB;
    pwdata  <= {16'h0000, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (r == REG_MAX_LEN) cfg_max_len = v;
    else cfg_timeout = v;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic reg_read_check(input efcr_reg_t r);
    logic [15:0] want;
    want = (r == REG_MAX_LEN) ? cfg_max_len : cfg_timeout;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'(r) << REG_IDX_LSB;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[15:0] != want)
      report_mismatch("register readback", 32'(want), 32'(prdata[15:0]));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // --------------------------------------------------------------- stimulus
  // holds the item until it is taken; random gaps before it
  task automatic send_line(input line_item_t li);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    op            <= li.op;
    rx_byte       <= li.rx;
    cur_chk       <= li.chk;
    cur_want_byte <= li.want_byte;
    cur_want_st   <= li.want_st;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drive_lines();
    while (line_q.size() != 0) begin
      send_line(line_q.pop_front());
    end
    in_valid <= 1'b0;
  endtask

  task automatic push_line(input efcr_op_t o, input logic [7:0] b);
    line_q.push_back('{o, b, CHK_MODEL, 8'h00, ST_OK});
  endtask

  // payload bytes lean on the marker values and their escaped forms
  function automatic logic [7:0] pick_payload_byte();
    logic [7:0] marks [8];
    marks = '{ESC_MARK, START_MARK, END_MARK, ESC_MARK ^ ESC_FLIP,
              START_MARK ^ ESC_FLIP, END_MARK ^ ESC_FLIP, 8'h00, 8'hFF};
    if ($urandom_range(0, 3) == 0) return marks[$urandom_range(0, 7)];
    return 8'($urandom_range(0, 255));
  endfunction

  // line noise between frames: ticks and stray bytes, never a start mark
  task automatic add_noise();
    logic [7:0] b;
    repeat ($urandom_range(0, 2)) begin
      b = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 1)) begin
        push_line(OP_TICK, b);
      end else begin
        if (b == START_MARK) b = 8'h00;
        push_line(OP_BYTE, b);
      end
    end
  endtask

  // one frame, mostly well formed; pick selects the kind of damage
  task automatic add_frame();
    logic [7:0]  body[$];
    logic [31:0] hlen;
    logic [15:0] fcs;
    logic [7:0]  b;
    int unsigned pick;
    int unsigned len;
    int unsigned n_send;
    int unsigned top;
    pick = $urandom_range(0, 99);
    top  = (cfg_max_len < 12) ? cfg_max_len : 12;
    len  = $urandom_range(0, top);
    hlen = len;
    // oversize headers: just above the limit, or a wild 32-bit value
    if (pick < 4) hlen = cfg_max_len + 1 + $urandom_range(0, 300);
    else if (pick < 8) hlen = $urandom | 32'h0001_0000;
    fcs = CRC_INIT;
    for (int i = 0; i < len; i++) begin
      b = pick_payload_byte();
      body.push_back(b);
      fcs = crc16_update(fcs, b);
    end
    // corrupted header crc
    if (pick >= 8 && pick < 16) fcs = 16'($urandom_range(0, 65535));
    push_line(OP_BYTE, START_MARK);
    for (int i = 0; i < 4; i++) push_line(OP_BYTE, hlen[8*i +: 8]);
    push_line(OP_BYTE, fcs[7:0]);
    push_line(OP_BYTE, fcs[15:8]);
    push_line(OP_BYTE, 8'($urandom_range(0, 255)));
    // stalled frame: enough ticks to run out the timeout
    if (pick >= 36 && pick < 42 && cfg_timeout <= 64) begin
      repeat (cfg_timeout + 1) push_line(OP_TICK, 8'($urandom_range(0, 255)));
      return;
    end
    // early end marker
    n_send = len;
    if (pick >= 16 && pick < 26 && len > 0) n_send = $urandom_range(0, len - 1);
    for (int i = 0; i < n_send; i++) begin
      if ($urandom_range(0, 9) == 0) push_line(OP_TICK, 8'($urandom_range(0, 255)));
      b = body[i];
      // escape and end markers must be escaped, other bytes sometimes are
      if (b == ESC_MARK || b == END_MARK || $urandom_range(0, 9) == 0) begin
        push_line(OP_BYTE, ESC_MARK);
        push_line(OP_BYTE, b ^ ESC_FLIP);
      end else begin
        push_line(OP_BYTE, b);
      end
    end
    // one data byte too many
    if (pick >= 26 && pick < 36) begin
      b = 8'($urandom_range(0, 255));
      if (b == ESC_MARK || b == END_MARK) b = b ^ 8'h01;
      push_line(OP_BYTE, b);
    end
    // frame left open, the next one runs into it
    if (pick >= 42 && pick < 46) return;
    push_line(OP_BYTE, END_MARK);
  endtask

  // let every pending result drain, then the block's input and result registers
  task automatic settle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // ------------------------------------------------------------- main flow
  initial begin
    logic [15:0] max_v;
    logic [15:0] tmo_v;
    cfg_max_len = MAX_LEN_RESET;
    cfg_timeout = TIMEOUT_RESET;
    clear_tracker();
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // limits must read back at their reset values
    reg_read_check(REG_MAX_LEN);
    reg_read_check(REG_TIMEOUT);

    // directed table under reset limits, slow receiver
    send_idle_pct  = 18;
    recv_stall_pct = 75;
    foreach (directed_rows[i]) line_q.push_back(directed_rows[i]);
    drive_lines();

    // random phases: slow receiver, then slow sender, then full rate
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph / 2)
        0: begin send_idle_pct = 18; recv_stall_pct = 75; end
        1: begin send_idle_pct = 75; recv_stall_pct = 18; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      case (ph)
        0: begin max_v = 16'd16;    tmo_v = 16'd40;    end
        1: begin max_v = 16'd0;     tmo_v = 16'd1;     end  // lowest limits
        2: begin max_v = 16'hFFFF;  tmo_v = 16'hFFFF;  end  // highest limits
        3: begin max_v = 16'd8;     tmo_v = 16'd3;     end
        4: begin
          max_v = 16'($urandom_range(0, 24));
          tmo_v = 16'($urandom_range(1, 30));
        end
        default: begin max_v = MAX_LEN_RESET; tmo_v = 16'($urandom_range(4, 64)); end
      endcase
      settle();
      reg_write(REG_MAX_LEN, max_v);
      reg_write(REG_TIMEOUT, tmo_v);
      reg_read_check(REG_MAX_LEN);
      reg_read_check(REG_TIMEOUT);
      while (line_q.size() < PHASE_ITEMS) begin
        add_noise();
        add_frame();
      end
      drive_lines();
    end

    // drain, then give a stray late result a chance to show up
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("escaped_frame_crc_receiver_top verification clean");
    end else begin
      $display("escaped_frame_crc_receiver_top verification failed");
    end
    $finish;
  end

endmodule

[escaped_frame_crc_receiver_top.f]
+incdir+rtl
rtl/efcr_pkg.sv
rtl/efcr_cfg_regs.sv
rtl/escaped_frame_crc_receiver_top.sv
tb/escaped_frame_crc_receiver_top_tb.sv
